@@ design/tws_pkg.sv @@
// Shared types, constants and BCD helpers for the three-wire serial master.
package tws_pkg;

   localparam int unsigned BcdMax      = 99;
   localparam int unsigned RecipMul    = 205;   // 205 / 2048 ~ 1 / 10 for values up to 99
   localparam int unsigned RecipShift  = 11;
   localparam int unsigned ByteBits    = 8;
   localparam int unsigned FrameBits   = 2 * ByteBits;
   localparam int unsigned PosWidth    = 5;
   localparam logic [3:0]  DigitMask   = 4'h0F;

   typedef struct packed {
      logic       start_req;
      logic       is_read;
      logic [7:0] command_byte;
      logic [7:0] write_value;
      logic       convert_bcd;
      logic       line_in;
   } req_type;

   typedef struct packed {
      logic       chip_enable;
      logic       serial_clock;
      logic       line_out;
      logic       line_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_value;
   } rsp_type;

   // Saturate at 99 and split into two decimal digits.
   function automatic logic [7:0] to_bcd(input logic [7:0] value);
      logic [6:0]  sat;
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  tens_x10;
      logic [6:0]  ones;
      sat      = (value > 8'(BcdMax)) ? 7'(BcdMax) : value[6:0];
      prod     = 15'(sat) * 15'(RecipMul);
      tens     = prod[RecipShift +: 4];
      tens_x10 = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
      ones     = sat - tens_x10;
      return {tens, ones[3:0]};
   endfunction

   // high digit * 10 + low digit, non-decimal digits included.
   function automatic logic [7:0] from_bcd(input logic [7:0] value);
      logic [3:0] hi;
      logic [3:0] lo;
      hi = value[7:4];
      lo = value[3:0] & DigitMask;
      return 8'({hi, 3'b000}) + 8'({hi, 1'b0}) + 8'(lo);
   endfunction

endpackage

@@ design/tws_if.sv @@
// Valid/ready channel interfaces for request and response words.
interface tws_req_if;
   logic       valid;
   logic       ready;
   logic       start_req;
   logic       is_read;
   logic [7:0] command_byte;
   logic [7:0] write_value;
   logic       convert_bcd;
   logic       line_in;

   modport source (output valid, start_req, is_read, command_byte, write_value,
                   convert_bcd, line_in, input ready);
   modport sink   (input valid, start_req, is_read, command_byte, write_value,
                   convert_bcd, line_in, output ready);
endinterface

interface tws_rsp_if;
   logic       valid;
   logic       ready;
   logic       chip_enable;
   logic       serial_clock;
   logic       line_out;
   logic       line_drive;
   logic       busy_res;
   logic       done_res;
   logic [7:0] read_value;

   modport source (output valid, chip_enable, serial_clock, line_out, line_drive,
                   busy_res, done_res, read_value, input ready);
   modport sink   (input valid, chip_enable, serial_clock, line_out, line_drive,
                   busy_res, done_res, read_value, output ready);
endinterface

@@ design/three_wire_rtc_serial_master.sv @@
// Three-wire serial master (LSB first, optional BCD), one tick per request word:
// each request word is one half period of the serial clock and yields exactly one
// response word carrying the line levels for that tick. A request word is held in
// an input register, the tick is evaluated by short logic against the transaction
// state, and the result lands in an output register, so one word is taken every
// cycle while the response side keeps up; a stalled response holds one word and
// the input register holds the next. A transaction lasts 33 ticks: 16 bits of two
// ticks each (command byte, then data byte) and a closing tick with done_res.
module three_wire_rtc_serial_master (
   input logic      clock,
   input logic      reset,
   tws_req_if.sink  req_if,
   tws_rsp_if.source rsp_if
);

   logic             in_valid_ff;
   tws_pkg::req_type in_item_ff;
   logic             out_valid_ff;
   tws_pkg::rsp_type out_res_ff;
   tws_pkg::rsp_type step_res;
   tws_pkg::req_type req_word;
   logic             advance;
   logic             req_take;

   assign advance  = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_take = req_if.valid && req_if.ready;

   assign req_if.ready = !in_valid_ff || advance;

   assign req_word.start_req    = req_if.start_req;
   assign req_word.is_read      = req_if.is_read;
   assign req_word.command_byte = req_if.command_byte;
   assign req_word.write_value  = req_if.write_value;
   assign req_word.convert_bcd  = req_if.convert_bcd;
   assign req_word.line_in      = req_if.line_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
      if (req_take) begin
         in_item_ff <= req_word;
      end
   end

   tws_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .result (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         out_res_ff <= step_res;
      end
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.chip_enable  = out_res_ff.chip_enable;
   assign rsp_if.serial_clock = out_res_ff.serial_clock;
   assign rsp_if.line_out     = out_res_ff.line_out;
   assign rsp_if.line_drive   = out_res_ff.line_drive;
   assign rsp_if.busy_res     = out_res_ff.busy_res;
   assign rsp_if.done_res     = out_res_ff.done_res;
   assign rsp_if.read_value   = out_res_ff.read_value;

`ifndef ASSERT_OFF
   a_advance_fills : assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("evaluated tick not registered");

   a_stall_holds_input : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_item_ff))
      else $error("held request word lost or changed");

   a_read_only_at_close : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_res_ff.read_value != 8'd0 |-> out_res_ff.done_res
         && !out_res_ff.chip_enable)
      else $error("read byte outside the closing tick");
`endif

endmodule

@@ design/tws_engine.sv @@
// Transaction state and per-tick line levels of the serial master.
module tws_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  tws_pkg::req_type item,
   output tws_pkg::rsp_type result
);

   logic                          active_ff, active_in;
   logic [tws_pkg::PosWidth-1:0]  pos_ff, pos_in;
   logic                          phase_ff, phase_in;
   logic [tws_pkg::FrameBits-1:0] send_ff, send_in;
   logic [tws_pkg::ByteBits-1:0]  recv_ff, recv_in;
   logic                          read_mode_ff, read_mode_in;
   logic                          bcd_mode_ff, bcd_mode_in;

   logic                          launch;
   logic                          run;
   logic [tws_pkg::PosWidth-1:0]  pos_eff;
   logic                          phase_eff;
   logic [tws_pkg::FrameBits-1:0] send_eff;
   logic [tws_pkg::ByteBits-1:0]  recv_eff;
   logic                          read_eff;
   logic                          bcd_eff;
   logic [7:0]                    data_byte;
   logic                          reading;

   assign launch = !active_ff && item.start_req;
   assign run    = active_ff || item.start_req;

   always_comb begin
      data_byte = item.convert_bcd ? tws_pkg::to_bcd(item.write_value) : item.write_value;
      if (item.is_read) begin
         data_byte = '0;
      end
      if (launch) begin
         pos_eff   = '0;
         phase_eff = 1'b0;
         send_eff  = {data_byte, item.command_byte};
         recv_eff  = '0;
         read_eff  = item.is_read;
         bcd_eff   = item.convert_bcd;
      end else begin
         pos_eff   = pos_ff;
         phase_eff = phase_ff;
         send_eff  = send_ff;
         recv_eff  = recv_ff;
         read_eff  = read_mode_ff;
         bcd_eff   = bcd_mode_ff;
      end
   end

   assign reading = read_eff && (pos_eff >= tws_pkg::PosWidth'(tws_pkg::ByteBits));

   always_comb begin
      result       = '0;
      active_in    = active_ff;
      pos_in       = pos_eff;
      phase_in     = phase_eff;
      send_in      = send_eff;
      recv_in      = recv_eff;
      read_mode_in = read_eff;
      bcd_mode_in  = bcd_eff;
      if (run) begin
         if (pos_eff >= tws_pkg::PosWidth'(tws_pkg::FrameBits)) begin
            // closing tick: drop enable, report the byte of a read
            result.done_res = 1'b1;
            if (read_eff) begin
               result.read_value = bcd_eff ? tws_pkg::from_bcd(recv_eff) : recv_eff;
            end
            active_in = 1'b0;
            pos_in    = '0;
            phase_in  = 1'b0;
         end else begin
            active_in           = 1'b1;
            result.chip_enable  = 1'b1;
            result.busy_res     = 1'b1;
            result.line_drive   = !reading;
            result.line_out     = !reading && send_eff[0];
            result.serial_clock = phase_eff;
            if (!phase_eff) begin
               if (reading) begin
                  recv_in = {item.line_in, recv_eff[tws_pkg::ByteBits-1:1]};
               end
               phase_in = 1'b1;
            end else begin
               send_in  = send_eff >> 1;
               pos_in   = pos_eff + tws_pkg::PosWidth'(1);
               phase_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         pos_ff       <= '0;
         phase_ff     <= 1'b0;
         send_ff      <= '0;
         recv_ff      <= '0;
         read_mode_ff <= 1'b0;
         bcd_mode_ff  <= 1'b0;
      end else if (step) begin
         active_ff    <= active_in;
         pos_ff       <= pos_in;
         phase_ff     <= phase_in;
         send_ff      <= send_in;
         recv_ff      <= recv_in;
         read_mode_ff <= read_mode_in;
         bcd_mode_ff  <= bcd_mode_in;
      end
   end

endmodule

@@ verif/three_wire_rtc_serial_master_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the three-wire serial master: tick-by-tick prediction and checking.
module three_wire_rtc_serial_master_test;

   localparam int HoldCycles  = 64;
   localparam int WatchLimit  = 1000;
   localparam int RandomWords = 215;
   localparam int MaxPrinted  = 40;
   localparam int DecimalBase = 10;
   localparam int FrameTicks  = 2 * int'(tws_pkg::FrameBits) + 1;

   typedef enum int {RxFree, RxCoin, RxPattern} stall_mode_type;

   class serial_frame_board;
      bit               active;
      logic [4:0]       bit_pos;
      bit               high_phase;
      logic [15:0]      send_shift;
      logic [7:0]       recv_shift;
      bit               read_mode;
      bit               bcd_mode;
      tws_pkg::rsp_type pending_ticks[$];
      int               errors;
      int               words_in;
      int               words_out;
      int               reads;
      int               writes;
      int               bcd_frames;

      function new();
         active     = 1'b0;
         bit_pos    = '0;
         high_phase = 1'b0;
         send_shift = '0;
         recv_shift = '0;
         read_mode  = 1'b0;
         bcd_mode   = 1'b0;
      endfunction

      function logic [7:0] encode_decimal(logic [7:0] v);
         int s;
         s = (v > tws_pkg::BcdMax) ? int'(tws_pkg::BcdMax) : int'(v);
         return {4'(s / DecimalBase), 4'(s % DecimalBase)};
      endfunction

      function logic [7:0] decode_decimal(logic [7:0] v);
         return 8'(int'(v[7:4]) * DecimalBase + int'(v[3:0]));
      endfunction

      // Work out the line levels for one accepted tick.
      function void note_request(tws_pkg::req_type w);
         tws_pkg::rsp_type r;
         logic [7:0]       data;
         bit               reading;
         r = '0;
         words_in++;
         if (!active) begin
            if (!w.start_req) begin
               pending_ticks.push_back(r);
               return;
            end
            read_mode = w.is_read;
            bcd_mode  = w.convert_bcd;
            data      = bcd_mode ? encode_decimal(w.write_value) : w.write_value;
            if (read_mode)
               data = '0;
            send_shift = {data, w.command_byte};
            recv_shift = '0;
            bit_pos    = '0;
            high_phase = 1'b0;
            active     = 1'b1;
            if (read_mode)
               reads++;
            else
               writes++;
            if (bcd_mode)
               bcd_frames++;
         end
         if (bit_pos >= tws_pkg::FrameBits) begin
            r.done_res = 1'b1;
            if (read_mode)
               r.read_value = bcd_mode ? decode_decimal(recv_shift) : recv_shift;
            active     = 1'b0;
            bit_pos    = '0;
            high_phase = 1'b0;
            pending_ticks.push_back(r);
            return;
         end
         reading       = read_mode && (bit_pos >= tws_pkg::ByteBits);
         r.chip_enable = 1'b1;
         r.busy_res    = 1'b1;
         r.line_drive  = !reading;
         r.line_out    = reading ? 1'b0 : send_shift[0];
         if (!high_phase) begin
            // sample the line in the low phase of each read data bit
            if (reading)
               recv_shift = {w.line_in, recv_shift[7:1]};
            high_phase = 1'b1;
         end else begin
            r.serial_clock = 1'b1;
            send_shift     = send_shift >> 1;
            bit_pos        = bit_pos + 5'd1;
            high_phase     = 1'b0;
         end
         pending_ticks.push_back(r);
      endfunction

      task report(string msg);
         errors++;
         if (errors <= MaxPrinted)
            $display("%0t: mismatch: %s", $time, msg);
      endtask

      task field_check(string name, logic [7:0] got, logic [7:0] want);
         if (got !== want)
            report($sformatf("word %0d %s: got %0h, want %0h", words_out, name, got, want));
      endtask

      task check_response(tws_pkg::rsp_type got);
         tws_pkg::rsp_type want;
         words_out++;
         if (pending_ticks.size() == 0) begin
            report($sformatf("word %0d arrived with nothing expected: %h", words_out, got));
            return;
         end
         want = pending_ticks.pop_front();
         field_check("chip_enable", 8'(got.chip_enable), 8'(want.chip_enable));
         field_check("serial_clock", 8'(got.serial_clock), 8'(want.serial_clock));
         field_check("line_out", 8'(got.line_out), 8'(want.line_out));
         field_check("line_drive", 8'(got.line_drive), 8'(want.line_drive));
         field_check("busy_res", 8'(got.busy_res), 8'(want.busy_res));
         field_check("done_res", 8'(got.done_res), 8'(want.done_res));
         field_check("read_value", got.read_value, want.read_value);
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   tws_req_if req_ch();
   tws_rsp_if rsp_ch();

   serial_frame_board board;
   int burst_left   = 0;
   int words_sent   = 0;
   int long_holds   = 0;
   int input_stalls = 0;
   int quiet_cycles = 0;
   bit hold_request = 1'b0;

   three_wire_rtc_serial_master u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always #10 clock = ~clock;

   function automatic tws_pkg::req_type random_word();
      tws_pkg::req_type w;
      w.start_req    = 1'($urandom_range(0, 1));
      w.is_read      = 1'($urandom_range(0, 1));
      w.command_byte = 8'($urandom_range(0, 255));
      w.write_value  = 8'($urandom_range(0, 255));
      w.convert_bcd  = 1'($urandom_range(0, 1));
      w.line_in      = 1'($urandom_range(0, 1));
      return w;
   endfunction

   // Offer one word, opening a new burst (possibly after a gap) when the last one is used up.
   task automatic send_word(input tws_pkg::req_type w);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      words_sent++;
      req_ch.valid        <= 1'b1;
      req_ch.start_req    <= w.start_req;
      req_ch.is_read      <= w.is_read;
      req_ch.command_byte <= w.command_byte;
      req_ch.write_value  <= w.write_value;
      req_ch.convert_bcd  <= w.convert_bcd;
      req_ch.line_in      <= w.line_in;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic idle_ticks(input int n);
      tws_pkg::req_type w;
      repeat (n) begin
         w = random_word();
         w.start_req = 1'b0;
         send_word(w);
      end
   endtask

   // One full transaction; later ticks are random and ignored, but sampled line_in uses pattern.
   task automatic run_frame(input logic rd, input logic [7:0] cmd, input logic [7:0] value,
                            input logic bcd, input logic [7:0] pattern);
      tws_pkg::req_type w;
      for (int t = 0; t < FrameTicks; t++) begin
         w = random_word();
         if (t == 0) begin
            w.start_req    = 1'b1;
            w.is_read      = rd;
            w.command_byte = cmd;
            w.write_value  = value;
            w.convert_bcd  = bcd;
         end
         if (t >= 2 * int'(tws_pkg::ByteBits) && t < 2 * int'(tws_pkg::FrameBits)
             && t % 2 == 0)
            w.line_in = pattern[(t - 2 * int'(tws_pkg::ByteBits)) / 2];
         send_word(w);
      end
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      do @(negedge clock); while (board.pending_ticks.size() != 0);
   endtask

   initial begin
      int kind;
      int frames;
      int directed_words;
      board = new();
      req_ch.valid        = 1'b0;
      req_ch.start_req    = 1'b0;
      req_ch.is_read      = 1'b0;
      req_ch.command_byte = '0;
      req_ch.write_value  = '0;
      req_ch.convert_bcd  = 1'b0;
      req_ch.line_in      = 1'b0;
      frames = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      idle_ticks(3);
      run_frame(1'b0, 8'h8E, 8'd0, 1'b1, 8'h00);
      run_frame(1'b0, 8'hFF, 8'd255, 1'b1, 8'hFF);
      run_frame(1'b0, 8'h00, 8'd100, 1'b1, 8'h00);
      run_frame(1'b0, 8'h80, 8'd99, 1'b1, 8'hFF);
      run_frame(1'b0, 8'h5A, 8'hA5, 1'b0, 8'h00);
      run_frame(1'b0, 8'hA5, 8'd255, 1'b0, 8'hFF);
      idle_ticks(2);
      // hold the output off while a read frame keeps coming in
      hold_request = 1'b1;
      run_frame(1'b1, 8'h81, 8'd255, 1'b1, 8'hFF);
      run_frame(1'b1, 8'h00, 8'd0, 1'b1, 8'h00);
      run_frame(1'b1, 8'hFF, 8'd77, 1'b1, 8'h59);
      run_frame(1'b1, 8'h83, 8'd12, 1'b0, 8'hA5);
      wait_drained();
      directed_words = words_sent;

      while (words_sent < directed_words + RandomWords) begin
         kind = $urandom_range(0, 19);
         if (kind < 3) begin
            idle_ticks($urandom_range(1, 3));
         end else if (kind < 5) begin
            // noise: may cut into or start frames at odd points
            repeat ($urandom_range(1, 40)) send_word(random_word());
         end else begin
            run_frame(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      8'($urandom_range(0, 255)));
            frames++;
            if (frames == 2 || frames == 5)
               hold_request = 1'b1;
            if (frames == 4)
               wait_drained();
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      $display("%0d ticks checked; %0d writes and %0d reads started, %0d with BCD conversion",
               board.words_out, board.writes, board.reads, board.bcd_frames);
      $display("%0d long output holds, %0d cycles of stalled input, %0d mismatches",
               long_holds, input_stalls, board.errors);
      if (board.errors == 0)
         $display("three_wire_rtc_serial_master_test: done, clean");
      else
         $display("three_wire_rtc_serial_master_test: done, errors");
      $finish;
   end

   // Output side: free running, coin toss or rotating mask, with an occasional long hold.
   initial begin
      stall_mode_type mode;
      int             left;
      logic [7:0]     mask;
      rsp_ch.ready = 1'b0;
      mode = RxFree;
      left = 0;
      mask = 8'hFF;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HoldCycles) @(negedge clock);
            long_holds++;
         end else begin
            if (left == 0) begin
               mode = stall_mode_type'($urandom_range(0, 2));
               left = $urandom_range(20, 120);
               mask = 8'($urandom_range(1, 255));
            end
            left--;
            unique case (mode)
               RxFree: rsp_ch.ready <= 1'b1;
               RxCoin: rsp_ch.ready <= 1'($urandom_range(0, 1));
               RxPattern: begin
                  rsp_ch.ready <= mask[0];
                  mask = {mask[0], mask[7:1]};
               end
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            board.note_request(tws_pkg::req_type'({req_ch.start_req, req_ch.is_read,
                                                   req_ch.command_byte, req_ch.write_value,
                                                   req_ch.convert_bcd, req_ch.line_in}));
         if (req_ch.valid && !req_ch.ready)
            input_stalls++;
         if (rsp_ch.valid && rsp_ch.ready)
            board.check_response(tws_pkg::rsp_type'({rsp_ch.chip_enable, rsp_ch.serial_clock,
                                                     rsp_ch.line_out, rsp_ch.line_drive,
                                                     rsp_ch.busy_res, rsp_ch.done_res,
                                                     rsp_ch.read_value}));
      end
   end

   // Drop out if neither side moves a word for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= WatchLimit) begin
            $display("timeout after %0d quiet cycles", WatchLimit);
            $display("three_wire_rtc_serial_master_test: done, errors");
            $finish;
         end
      end
   end

endmodule
